>>> src/esma_pkg.sv
package esma_pkg;

   localparam int CountFieldW = 16;
   localparam int CfgW        = 16;
   localparam int SpeedW      = 15;
   localparam int DivW        = 24;
   localparam int DiffW       = 18;
   localparam int CsrIdxW     = 2;

   localparam logic [SpeedW-1:0]  SpeedMax         = 15'h7fff;
   localparam logic [DivW-1:0]    SecondsPerMinute = 24'd60;
   localparam logic [CfgW-1:0]    CounterTopReset  = 16'hffff;
   localparam logic [CfgW-1:0]    RpmDivisorReset  = 16'd1;

   localparam logic [CsrIdxW-1:0] CsrCounterTop = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrRpmDivisor = 2'd1;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [CfgW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

>>> src/esma_div.sv
module esma_div (
   input  logic                 clock,
   input  logic                 reset,
   input  esma_pkg::div_req_type div_req,
   output esma_pkg::div_rsp_type div_rsp
);

   localparam int DivW  = esma_pkg::DivW;
   localparam int CfgW  = esma_pkg::CfgW;
   localparam int Steps = DivW / 2;
   localparam int StepW = $clog2(Steps);

   logic [CfgW-1:0]  rem_ff;
   logic [DivW-1:0]  quo_ff;
   logic [CfgW-1:0]  divisor_ff;
   logic [StepW-1:0] step_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [CfgW-1:0]  rem_in;
   logic [DivW-1:0]  quo_in;

   // two restoring steps per cycle
   always_comb begin
      logic [CfgW:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, quo_in[DivW-1]};
         quo_in = {quo_in[DivW-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in    = CfgW'(trial - {1'b0, divisor_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[CfgW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (div_req.start) begin
            rem_ff     <= '0;
            quo_ff     <= div_req.dividend;
            divisor_ff <= div_req.divisor;
            step_ff    <= '0;
            busy_ff    <= 1'b1;
            done_ff    <= 1'b0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            if (step_ff == StepW'(Steps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
               done_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> src/encoder_speed_with_moving_average_unit.sv
// channel  direction  beat contents
// req_     in         encoder_count, count_down
// rsp_     out        speed_rpm, average_rpm
// csr_     in         index (0 counter_top, 1 rpm_divisor), wdata
//
// a moving sample runs two divisions between req beat and rsp_valid (rpm, then window
// mean) on one shared divider that retires 2 quotient bits a cycle; with the
// count unchanged or the difference not positive the rpm division is skipped
// req_ready is high only while the sequencer is idle; the rsp register holds a
// finished beat, so the next sample can be taken while it waits for rsp_ready
// reset clears the ring at once through per-entry valid bits, no clearing pass
module encoder_speed_with_moving_average_unit #(
   parameter int WINDOW      = 50,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [esma_pkg::CountFieldW-1:0]     req_encoder_count,
   input  logic                                 req_count_down,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [esma_pkg::SpeedW-1:0]          rsp_speed_rpm,
   output logic [esma_pkg::SpeedW-1:0]          rsp_average_rpm,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [esma_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [esma_pkg::CfgW-1:0]            csr_wdata
);

   localparam int CntW   = (COUNT_WIDTH < esma_pkg::CountFieldW) ? COUNT_WIDTH
                                                                : esma_pkg::CountFieldW;
   localparam int SpeedW = esma_pkg::SpeedW;
   localparam int DivW   = esma_pkg::DivW;
   localparam int DiffW  = esma_pkg::DiffW;
   localparam int CfgW   = esma_pkg::CfgW;
   localparam int SumMax = WINDOW * 32767;
   localparam int SumW   = $clog2(SumMax + 1);
   localparam int PosW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CALC, S_DIV_RPM, S_SUM, S_DIV_AVG, S_FINISH
   } state_type;

   state_type          state_ff;
   logic [CfgW-1:0]    top_ff;
   logic [CfgW-1:0]    divisor_ff;
   logic [CntW-1:0]    cur_ff;
   logic               down_ff;
   logic [CntW-1:0]    prev_ff;
   logic [PosW-1:0]    pos_ff;
   logic [SumW-1:0]    sum_ff;
   logic [SpeedW-1:0]  rpm_ff;
   logic [SpeedW-1:0]  old_raw_ff;
   logic               old_vld_ff;
   logic [WINDOW-1:0]  valid_ff;
   logic               rsp_valid_ff;
   logic [SpeedW-1:0]  rsp_speed_rpm_ff;
   logic [SpeedW-1:0]  rsp_average_rpm_ff;

   logic [SpeedW-1:0]  ring_mem [WINDOW];

   logic signed [DiffW-1:0] cur_x, prev_x, top_x, diff;
   logic                    moved;
   logic                    run_rpm;
   logic [DivW-1:0]         product;
   logic [SpeedW-1:0]       old_speed;
   logic [SpeedW-1:0]       rpm_sat;
   logic [SumW-1:0]         sum_in;
   logic                    req_beat;

   esma_pkg::div_req_type div_req;
   esma_pkg::div_rsp_type div_rsp;

   assign req_beat = req_valid && req_ready;

   // count difference with wrap correction, can go negative for a small top
   always_comb begin
      cur_x  = $signed(DiffW'(cur_ff));
      prev_x = $signed(DiffW'(prev_ff));
      top_x  = $signed(DiffW'(top_ff));
      moved  = (cur_ff != prev_ff);
      if (!down_ff) begin
         diff = (cur_x < prev_x) ? cur_x + top_x - prev_x : cur_x - prev_x;
      end else begin
         diff = (cur_x > prev_x) ? prev_x + top_x - cur_x : prev_x - cur_x;
      end
      run_rpm = moved && (diff > 0);
      product = DivW'(diff[CfgW-1:0]) * esma_pkg::SecondsPerMinute;
   end

   assign old_speed = old_vld_ff ? old_raw_ff : '0;
   assign rpm_sat   = (|div_rsp.quotient[DivW-1:SpeedW]) ? esma_pkg::SpeedMax
                                                         : div_rsp.quotient[SpeedW-1:0];
   assign sum_in    = sum_ff - SumW'(old_speed) + SumW'(rpm_ff);

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = product;
      div_req.divisor  = divisor_ff;
      if (state_ff == S_CALC) begin
         div_req.start = run_rpm;
      end else if (state_ff == S_SUM) begin
         div_req.start    = 1'b1;
         div_req.dividend = DivW'(sum_in);
         div_req.divisor  = CfgW'(WINDOW);
      end
   end

   esma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         ring_mem[pos_ff] <= rpm_ff;
      end
      if (req_beat) begin
         old_raw_ff <= ring_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= esma_pkg::CounterTopReset;
         divisor_ff   <= esma_pkg::RpmDivisorReset;
         prev_ff      <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               esma_pkg::CsrCounterTop: top_ff     <= csr_wdata;
               esma_pkg::CsrRpmDivisor: divisor_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  cur_ff     <= req_encoder_count[CntW-1:0];
                  down_ff    <= req_count_down;
                  old_vld_ff <= valid_ff[pos_ff];
                  state_ff   <= S_CALC;
               end
            end
            S_CALC: begin
               if (moved) begin
                  prev_ff <= cur_ff;
               end
               if (run_rpm) begin
                  state_ff <= S_DIV_RPM;
               end else begin
                  rpm_ff   <= '0;
                  state_ff <= S_SUM;
               end
            end
            S_DIV_RPM: begin
               if (div_rsp.done) begin
                  rpm_ff   <= rpm_sat;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff           <= sum_in;
               valid_ff[pos_ff] <= 1'b1;
               pos_ff           <= (pos_ff == PosW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
               state_ff         <= S_DIV_AVG;
            end
            S_DIV_AVG: begin
               if (div_rsp.done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // wait for the output register to be free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_speed_rpm_ff   <= rpm_ff;
                  rsp_average_rpm_ff <= div_rsp.quotient[SpeedW-1:0];
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_rpm   = rsp_speed_rpm_ff;
   assign rsp_average_rpm = rsp_average_rpm_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(WINDOW - 1))
      else $error("ring position out of range");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SumW'(SumMax))
      else $error("window sum out of range");

endmodule
